// ----- rtl/activation_with_derivative_defines.svh -----
// Assertion macros used by the activation-with-derivative RTL
`ifndef ACTIVATION_WITH_DERIVATIVE_DEFINES_SVH
`define ACTIVATION_WITH_DERIVATIVE_DEFINES_SVH

// Check a property on every clock edge outside reset
`define AWD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define AWD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/awd_pkg.sv -----
// Shared types, constants and exp table builder for the activation block
package awd_pkg;

  // Number of table intervals over [-8, 8]
  localparam int unsigned EXP_ENTRIES = 256;
  // Table index width, holds 0..EXP_ENTRIES
  localparam int unsigned IDX_W = $clog2(EXP_ENTRIES + 1);
  // Width of u * EXP_ENTRIES with u up to 2^16
  localparam int unsigned POS_W = 16 + IDX_W;
  // Register stages inside the exp lookup
  localparam int unsigned LK_LAT = 4;
  // Quotient bits per divider chain (results never exceed 2^19)
  localparam int unsigned QUO_W = 20;
  // Rounded dividend width: remainder part plus quotient part
  localparam int unsigned DVD_W = 32 + QUO_W;

  localparam logic [31:0] ONE_Q19 = 32'h0008_0000;
  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef enum logic [1:0] {
    FN_EXP  = 2'd0,
    FN_SIG  = 2'd1,
    FN_TANH = 2'd2
  } func_e;

  // Item travelling down a divider chain together with its sideband
  typedef struct packed {
    logic             vld;
    func_e            mode;
    logic             neg;
    logic [31:0]      pass;
    logic [31:0]      den;
    logic [31:0]      rem;
    logic [QUO_W-1:0] dvd_lo;
    logic [QUO_W-1:0] quo;
  } div_t;

  // Taylor sum of e^f (or e^-f) in Q30 over 25 terms, up to the f^24 term
  function automatic longint unsigned taylor_q30(longint unsigned f, bit negate);
    longint unsigned sum;
    longint unsigned term;
    sum  = ONE_Q30;
    term = ONE_Q30;
    for (int n = 1; n <= 24; n++) begin
      term = ((term * f) >> 30) / 64'(n);
      if (negate && n[0]) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  // Table point i: e^a in unsigned Q19, a = -8 + 16*i/EXP_ENTRIES
  function automatic logic [31:0] exp_point(int unsigned i);
    longint a;
    longint unsigned m;
    longint unsigned k;
    longint unsigned f;
    longint unsigned v;
    longint unsigned e1;
    a = longint'((64'(i) << 34) / 64'(EXP_ENTRIES)) - longint'(64'd8 << 30);
    if (a < 0) m = 64'(-a);
    else m = 64'(a);
    k = m >> 30;
    if (k > 64'd8) k = 64'd8;
    f = m & (ONE_Q30 - 64'd1);
    if (a >= 0) begin
      e1 = taylor_q30(ONE_Q30, 1'b0);
      v  = (taylor_q30(f, 1'b0) + 64'd512) >> 10;
      for (int j = 0; j < 8; j++) begin
        if (64'(j) < k) v = (v * e1) >> 30;
      end
      v = (v + 64'd1) >> 1;
    end else begin
      e1 = taylor_q30(ONE_Q30, 1'b1);
      v  = taylor_q30(f, 1'b1);
      for (int j = 0; j < 8; j++) begin
        if (64'(j) < k) v = (v * e1) >> 30;
      end
      v = (v + 64'd1024) >> 11;
    end
    if (v > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
    return v[31:0];
  endfunction

endpackage

// ----- rtl/awd_exp_lookup.sv -----
// Four-stage interpolated e^x lookup over the constant exp table
module awd_exp_lookup (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [16:0] u_i,
  output logic [31:0] exp_o
);
  import awd_pkg::*;

  logic [31:0]      tbl_w [EXP_ENTRIES+1];
  logic [POS_W-1:0] pos_q;
  logic [IDX_W-1:0] idx;
  logic [31:0]      lo_d, hi_d, lo_q, hi_q, lo2_q, mag, exp_q;
  logic [15:0]      fr_d, fr_q;
  logic             neg_q;
  logic [47:0]      prod_q, rnd;
  logic [31:0]      adj;

  // Build the constant table at elaboration
  for (genvar g = 0; g <= EXP_ENTRIES; g++) begin : g_tbl
    localparam logic [31:0] Point = exp_point(g);
    assign tbl_w[g] = Point;
  end

  // Select the two neighbouring points, clamp at the top end
  always_comb begin
    idx = pos_q[POS_W-1:16];
    if (idx >= IDX_W'(EXP_ENTRIES)) begin
      lo_d = tbl_w[EXP_ENTRIES];
      hi_d = tbl_w[EXP_ENTRIES];
      fr_d = '0;
    end else begin
      lo_d = tbl_w[idx];
      hi_d = tbl_w[idx + IDX_W'(1)];
      fr_d = pos_q[15:0];
    end
  end

  assign mag = (hi_q < lo_q) ? (lo_q - hi_q) : (hi_q - lo_q);
  assign rnd = prod_q + 48'd32768;
  assign adj = rnd[47:16];

  // Advance the lookup stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_q  <= POS_W'(u_i) * POS_W'(EXP_ENTRIES);
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      fr_q   <= fr_d;
      prod_q <= 48'(mag) * 48'(fr_q);
      lo2_q  <= lo_q;
      neg_q  <= hi_q < lo_q;
      exp_q  <= neg_q ? (lo2_q - adj) : (lo2_q + adj);
    end
  end

  assign exp_o = exp_q;

  // Reset input kept for a uniform stage interface
  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule

// ----- rtl/awd_div_cell.sv -----
// One restoring-division cell: resolves one quotient bit per transfer
module awd_div_cell (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  awd_pkg::div_t in_i,
  output awd_pkg::div_t out_o
);
  import awd_pkg::*;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;
  div_t        cell_d, cell_q;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial  = {in_i.rem, in_i.dvd_lo[QUO_W-1]};
    diff   = trial - {1'b0, in_i.den};
    ge     = trial >= {1'b0, in_i.den};
    cell_d = in_i;
    cell_d.rem    = ge ? diff[31:0] : trial[31:0];
    cell_d.dvd_lo = {in_i.dvd_lo[QUO_W-2:0], 1'b0};
    cell_d.quo    = {in_i.quo[QUO_W-2:0], ge};
  end

  // Hand the item on to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.vld <= 1'b0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign out_o = cell_q;

endmodule

// ----- rtl/activation_with_derivative.sv -----
// Top level: two exp lookups, two divider cell chains and output skid stage
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------------
//  in       | in_valid_i / in_ready_o      | sample_in_i
//  out      | out_valid_o / out_ready_i    | activation_value_o, derivative_value_o
//  cfg      | cfg_valid_i / cfg_ready_o    | function_select_i
//
// One sample per cycle while the skid register is empty; the pipeline runs through two 20-cell divider chains.
// Every stage advances together; a skid register behind the output register
// absorbs one result, and the input stalls only while the skid register is full.
// Reset clears valid bits and the function select (sigmoid); no clearing pass.
`include "activation_with_derivative_defines.svh"

module activation_with_derivative (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] sample_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] activation_value_o,
  output logic signed [31:0] derivative_value_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         function_select_i
);
  import awd_pkg::*;

  func_e       func_q;
  logic        en;
  logic        s0_vld_q;
  func_e       s0_mode_q;
  logic [15:0] s0_smp_q;
  logic [16:0] u_pos, u_neg;
  logic [31:0] ep_w, em_w;
  logic        lk_vld_q  [LK_LAT];
  func_e       lk_mode_q [LK_LAT];

  div_t        pa_d, pa_q, pb_d, pb_q;
  div_t        div_a_w [QUO_W+1];
  div_t        div_b_w [QUO_W+1];
  logic [31:0] den_a, den_b, diff_a;
  logic [DVD_W-1:0] nd_a, nd_b;

  logic        f_vld_q, f_neg_q;
  func_e       f_mode_q;
  logic [31:0] f_pass_q;
  logic [QUO_W-1:0] f_qb_q;
  logic [39:0] f_sq_q;
  logic [40:0] sq_rnd;
  logic [31:0] fin_act, fin_der;

  logic        out_valid_q, sk_valid_q, take;
  logic [31:0] out_act_q, out_der_q, sk_act_q, sk_der_q;

  // Configuration register, always ready
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_q <= FN_SIG;
    end else if (cfg_valid_i) begin
      func_q <= func_e'(function_select_i);
    end
  end

  // Advance the whole pipeline while the skid register is free
  assign en         = !sk_valid_q;
  assign in_ready_o = en;

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_smp_q  <= sample_in_i;
      s0_mode_q <= func_q;
    end
  end

  // Table coordinates for e^x and e^-x
  assign u_pos = {1'b0, s0_smp_q ^ 16'h8000};
  assign u_neg = 17'h1_0000 - u_pos;

  awd_exp_lookup u_lk_pos (
    .clk_i (clk_i), .rst_ni(rst_ni), .en_i(en), .u_i(u_pos), .exp_o(ep_w)
  );
  awd_exp_lookup u_lk_neg (
    .clk_i (clk_i), .rst_ni(rst_ni), .en_i(en), .u_i(u_neg), .exp_o(em_w)
  );

  // Carry valid and mode alongside the lookup stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LK_LAT; i++) lk_vld_q[i] <= 1'b0;
    end else if (en) begin
      lk_vld_q[0] <= s0_vld_q;
      for (int i = 1; i < LK_LAT; i++) lk_vld_q[i] <= lk_vld_q[i-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      lk_mode_q[0] <= s0_mode_q;
      for (int i = 1; i < LK_LAT; i++) lk_mode_q[i] <= lk_mode_q[i-1];
    end
  end

  // Set up the first division: sigmoid value or tanh magnitude, exp passes through
  always_comb begin
    pa_d      = '0;
    pa_d.vld  = lk_vld_q[LK_LAT-1];
    pa_d.mode = lk_mode_q[LK_LAT-1];
    pa_d.pass = ep_w;
    den_a     = '0;
    diff_a    = '0;
    nd_a      = '0;
    case (lk_mode_q[LK_LAT-1])
      FN_SIG: begin
        den_a = ep_w + ONE_Q19;
        nd_a  = DVD_W'({ep_w, 19'b0}) + DVD_W'(den_a >> 1);
      end
      FN_TANH: begin
        pa_d.neg = ep_w < em_w;
        diff_a   = (ep_w < em_w) ? (em_w - ep_w) : (ep_w - em_w);
        den_a    = ep_w + em_w;
        nd_a     = DVD_W'({diff_a, 19'b0}) + DVD_W'(den_a >> 1);
      end
      default: begin
        den_a = '0;
      end
    endcase
    pa_d.den    = den_a;
    pa_d.rem    = nd_a[DVD_W-1:QUO_W];
    pa_d.dvd_lo = nd_a[QUO_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_q.vld <= 1'b0;
    end else if (en) begin
      pa_q <= pa_d;
    end
  end

  // First divider chain
  assign div_a_w[0] = pa_q;
  for (genvar k = 0; k < QUO_W; k++) begin : g_div_a
    awd_div_cell u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .in_i(div_a_w[k]), .out_o(div_a_w[k+1])
    );
  end

  // Set up the second division: sigmoid derivative, others pass through
  always_comb begin
    pb_d        = div_a_w[QUO_W];
    pb_d.quo    = '0;
    pb_d.pass   = (div_a_w[QUO_W].mode == FN_EXP) ? div_a_w[QUO_W].pass
                                                  : 32'(div_a_w[QUO_W].quo);
    den_b       = '0;
    nd_b        = '0;
    if (div_a_w[QUO_W].mode == FN_SIG) begin
      den_b = div_a_w[QUO_W].den;
      nd_b  = DVD_W'({div_a_w[QUO_W].quo, 19'b0}) + DVD_W'(den_b >> 1);
    end
    pb_d.den    = den_b;
    pb_d.rem    = nd_b[DVD_W-1:QUO_W];
    pb_d.dvd_lo = nd_b[QUO_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pb_q.vld <= 1'b0;
    end else if (en) begin
      pb_q <= pb_d;
    end
  end

  // Second divider chain
  assign div_b_w[0] = pb_q;
  for (genvar k = 0; k < QUO_W; k++) begin : g_div_b
    awd_div_cell u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .in_i(div_b_w[k]), .out_o(div_b_w[k+1])
    );
  end

  // Square the tanh magnitude
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= div_b_w[QUO_W].vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      f_mode_q <= div_b_w[QUO_W].mode;
      f_neg_q  <= div_b_w[QUO_W].neg;
      f_pass_q <= div_b_w[QUO_W].pass;
      f_qb_q   <= div_b_w[QUO_W].quo;
      f_sq_q   <= 40'(div_b_w[QUO_W].pass[QUO_W-1:0]) * 40'(div_b_w[QUO_W].pass[QUO_W-1:0]);
    end
  end

  // Form the final value and derivative, saturate exp
  assign sq_rnd = 41'(f_sq_q) + 41'(ONE_Q19 >> 1);
  always_comb begin
    case (f_mode_q)
      FN_EXP: begin
        fin_act = f_pass_q[31] ? SAT_MAX : f_pass_q;
        fin_der = fin_act;
      end
      FN_SIG: begin
        fin_act = f_pass_q;
        fin_der = 32'(f_qb_q);
      end
      FN_TANH: begin
        fin_act = f_neg_q ? (32'd0 - f_pass_q) : f_pass_q;
        fin_der = ONE_Q19 - 32'(sq_rnd[39:19]);
      end
      default: begin
        fin_act = '0;
        fin_der = '0;
      end
    endcase
  end

  // Output register with one skid entry behind it
  assign take = out_valid_q && out_ready_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sk_valid_q  <= 1'b0;
    end else if (sk_valid_q) begin
      if (take) sk_valid_q <= 1'b0;
    end else if (f_vld_q) begin
      if (!out_valid_q || take) out_valid_q <= 1'b1;
      else sk_valid_q <= 1'b1;
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (sk_valid_q) begin
      if (take) begin
        out_act_q <= sk_act_q;
        out_der_q <= sk_der_q;
      end
    end else if (f_vld_q) begin
      if (!out_valid_q || take) begin
        out_act_q <= fin_act;
        out_der_q <= fin_der;
      end else begin
        sk_act_q <= fin_act;
        sk_der_q <= fin_der;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign activation_value_o = out_act_q;
  assign derivative_value_o = out_der_q;

  // Skid entry never holds data without a result on show
  `AWD_ASSERT_ALWAYS(a_skid_behind_out, (!rst_ni || !sk_valid_q || out_valid_q), "skid full with output empty")
  // Skid fills only when the output was stalled
  `AWD_ASSERT(a_skid_fill, ($rose(sk_valid_q) |-> $past(out_valid_q && !out_ready_i)), "skid filled without a stall")
  // First chain leaves a proper remainder
  `AWD_ASSERT(a_div_rem, ((div_a_w[QUO_W].vld && div_a_w[QUO_W].den != 32'd0) |-> (div_a_w[QUO_W].rem < div_a_w[QUO_W].den)), "divider remainder out of range")
  // Sigmoid value and derivative stay within one
  `AWD_ASSERT(a_sig_range, ((f_vld_q && f_mode_q == FN_SIG) |-> (f_pass_q <= ONE_Q19 && 32'(f_qb_q) <= ONE_Q19)), "sigmoid result above one")

endmodule
